>>> rtl/core/rbst_pkg.sv
// shared types and constants for the ray box slab test
`default_nettype none

package rbst_pkg;

   localparam int AXES       = 3;
   localparam int LANES      = 2 * AXES;
   localparam int FIX_W      = 32;
   localparam int DIFF_W     = FIX_W + 1;
   localparam int PROD_W     = DIFF_W + FIX_W;
   localparam int REQ_FIELDS = 4 * AXES;
   localparam int REQ_W      = REQ_FIELDS * FIX_W;
   localparam int RSP_USED_W = 1 + 2 * FIX_W;
   localparam int RSP_W      = ((RSP_USED_W + 7) / 8) * 8;

   typedef logic signed [FIX_W-1:0]  fix_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam fix_type POS_INF = 32'sh7FFF_FFFF;
   localparam fix_type NEG_INF = 32'sh8000_0000;

endpackage

`default_nettype wire

>>> rtl/core/ray_box_slab_test.sv
// ray against axis-aligned box slab test, six-stage pipeline
//
//  channel | dir | word fields (lowest bit up)
//  req     | in  | box_min_x/y/z, box_max_x/y/z, origin_x/y/z, inv_dir_x/y/z (32 b each)
//  rsp     | out | hit (1 b), t_near (32 b), t_far (32 b), zero pad to 72 b
//
// one word per cycle in and out while rsp is not stalled
// stages: subtract, multiply, shift and saturate, per-axis min/max, reduce, hit
// each stage moves when the one after it is empty or moving, so bubbles close up
// a stall on rsp holds every word in place; nothing is lost or repeated
// reset clears the valid bits only
`default_nettype none

module ray_box_slab_test #(
   parameter int FRAC_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
   // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z
   input  wire  [rbst_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // hit, t_near, t_far, zero pad
   output logic [rbst_pkg::RSP_W-1:0]   rsp_tdata
);
   import rbst_pkg::*;

   localparam prod_type SAT_HI = PROD_W'(POS_INF);
   localparam prod_type SAT_LO = PROD_W'(NEG_INF);

   // stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   // stage 1: differences and inverse directions
   diff_type s1_diff_ff [LANES];
   diff_type s1_diff_in [LANES];
   fix_type  s1_inv_ff  [AXES];

   // stage 2: products and flags
   prod_type s2_prod_ff [LANES];
   prod_type s2_prod_in [LANES];
   logic     s2_neg_ff  [LANES];
   logic     s2_zero_ff [LANES];
   logic     s2_inf_ff  [AXES];

   // stage 3: slab parameters
   fix_type  s3_param_ff [LANES];
   fix_type  s3_param_in [LANES];
   logic     s3_undef_ff [AXES];

   // stage 4: per-axis bounds
   fix_type  s4_lo_ff [AXES];
   fix_type  s4_hi_ff [AXES];

   // stage 5: reduced bounds
   fix_type  s5_near_ff, s5_far_ff, s5_near_in, s5_far_in;

   // stage 6: output word
   logic     s6_hit_ff;
   fix_type  s6_near_ff, s6_far_ff;

   assign en6 = !v6_ff || rsp_tready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // stage 1
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s1_diff_in[l] = DIFF_W'($signed(req_tdata[l*FIX_W +: FIX_W]))
                       - DIFF_W'($signed(req_tdata[(2*AXES + l%AXES)*FIX_W +: FIX_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_tvalid) begin
         for (int l = 0; l < LANES; l++) s1_diff_ff[l] <= s1_diff_in[l];
         for (int a = 0; a < AXES; a++) begin
            s1_inv_ff[a] <= fix_type'(req_tdata[(3*AXES + a)*FIX_W +: FIX_W]);
         end
      end
   end

   // stage 2
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s2_prod_in[l] = PROD_W'(s1_diff_ff[l]) * PROD_W'(s1_inv_ff[l%AXES]);
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         for (int l = 0; l < LANES; l++) begin
            s2_prod_ff[l] <= s2_prod_in[l];
            s2_neg_ff[l]  <= s1_diff_ff[l][DIFF_W-1] ^ s1_inv_ff[l%AXES][FIX_W-1];
            s2_zero_ff[l] <= (s1_diff_ff[l] == '0);
         end
         for (int a = 0; a < AXES; a++) begin
            s2_inf_ff[a] <= (s1_inv_ff[a] == POS_INF) || (s1_inv_ff[a] == NEG_INF);
         end
      end
   end

   // stage 3
   always_comb begin
      prod_type shifted;
      for (int l = 0; l < LANES; l++) begin
         shifted = s2_prod_ff[l] >>> FRAC_BITS;
         if (s2_inf_ff[l%AXES]) begin
            s3_param_in[l] = s2_neg_ff[l] ? NEG_INF : POS_INF;
         end else if (shifted > SAT_HI) begin
            s3_param_in[l] = POS_INF;
         end else if (shifted < SAT_LO) begin
            s3_param_in[l] = NEG_INF;
         end else begin
            s3_param_in[l] = fix_type'(shifted[FIX_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         for (int l = 0; l < LANES; l++) s3_param_ff[l] <= s3_param_in[l];
         for (int a = 0; a < AXES; a++) begin
            s3_undef_ff[a] <= s2_inf_ff[a] && (s2_zero_ff[a] || s2_zero_ff[a+AXES]);
         end
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (en4 && v3_ff) begin
         for (int a = 0; a < AXES; a++) begin
            if (s3_undef_ff[a]) begin
               s4_lo_ff[a] <= NEG_INF;
               s4_hi_ff[a] <= POS_INF;
            end else if (s3_param_ff[a] < s3_param_ff[a+AXES]) begin
               s4_lo_ff[a] <= s3_param_ff[a];
               s4_hi_ff[a] <= s3_param_ff[a+AXES];
            end else begin
               s4_lo_ff[a] <= s3_param_ff[a+AXES];
               s4_hi_ff[a] <= s3_param_ff[a];
            end
         end
      end
   end

   // stage 5
   always_comb begin
      s5_near_in = s4_lo_ff[0];
      s5_far_in  = s4_hi_ff[0];
      for (int a = 1; a < AXES; a++) begin
         if (s4_lo_ff[a] > s5_near_in) s5_near_in = s4_lo_ff[a];
         if (s4_hi_ff[a] < s5_far_in) s5_far_in = s4_hi_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (en5 && v4_ff) begin
         s5_near_ff <= s5_near_in;
         s5_far_ff  <= s5_far_in;
      end
   end

   // stage 6
   always_ff @(posedge clock) begin
      if (en6 && v5_ff) begin
         s6_hit_ff  <= !s5_far_ff[FIX_W-1] && (s5_far_ff >= s5_near_ff);
         s6_near_ff <= s5_near_ff;
         s6_far_ff  <= s5_far_ff;
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = {{(RSP_W-RSP_USED_W){1'b0}}, s6_far_ff, s6_near_ff, s6_hit_ff};

endmodule

`default_nettype wire

>>> rtl/core/rbst_check.sv
// port checks for the ray box slab test
`default_nettype none

module rbst_check (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_tready,
   input wire                        rsp_tvalid,
   input wire                        rsp_tready,
   input wire [rbst_pkg::RSP_W-1:0]  rsp_tdata
);
   import rbst_pkg::*;

   fix_type t_near, t_far;
   logic    hit;

   assign hit    = rsp_tdata[0];
   assign t_near = fix_type'(rsp_tdata[FIX_W:1]);
   assign t_far  = fix_type'(rsp_tdata[2*FIX_W:FIX_W+1]);

   // no word leaves right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word right after reset");

   // hit flag agrees with the bounds it is sent with
   a_hit_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hit == ((t_far >= 0) && (t_far >= t_near))))
      else $error("hit flag disagrees with t_near and t_far");

   // padding stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_W-1:RSP_USED_W] == '0))
      else $error("rsp pad bits not zero");

   // a stalled word stays and holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed or dropped");

   // input is never blocked while the output side is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("req blocked with a free output");

endmodule

bind ray_box_slab_test rbst_check u_rbst_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
